// ===== sv/lfxr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfxr_pkg
// Shared types and constants for the length-framed xor-header receiver.
// ----------------------------------------------------------------------------
package lfxr_pkg;

  // receive buffer size; the body limit leaves room for the four header bytes
  localparam int unsigned BUFFER_BYTES = 256;
  localparam logic [15:0] LEN_CAP      = 16'(BUFFER_BYTES - 4);

  // configuration register indexes
  localparam logic CFG_START_BYTE   = 1'b0;
  localparam logic CFG_MAX_BODY_LEN = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] START_BYTE_RST   = 8'd254;
  localparam logic [7:0] MAX_BODY_LEN_RST = 8'd251;

  // result event codes
  localparam logic EV_PAYLOAD = 1'b0;
  localparam logic EV_REJECT  = 1'b1;

  // frame parser phases
  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_START = 5'b00010,
    PH_CKSM  = 5'b00100,
    PH_LENH  = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_t;

  // one result item
  typedef struct packed {
    logic        event_kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ===== sv/lfxr_in_stage.sv =====
// ----------------------------------------------------------------------------
// lfxr_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module lfxr_in_stage import lfxr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       adv_ok,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  // the held byte moves on whenever the result side can load
  assign in_stall  = valid_r && !adv_ok;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take ? 1'b1 : (adv_ok ? 1'b0 : valid_r);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // byte capture on each input transfer
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// ===== sv/lfxr_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// lfxr_frame_fsm
// Frame parser: header capture, checksum and length checks, body counting.
// ----------------------------------------------------------------------------
module lfxr_frame_fsm import lfxr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] start_byte,
  input  logic [7:0] max_body_len,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cksum_r, cksum_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [7:0]  remain_r, remain_nxt;

  logic [15:0] len;
  logic [7:0]  want;
  logic [15:0] limit;
  logic        hdr_ok;
  logic        fin;

  // header checks on the length-low byte
  assign len    = {len_hi_r, rx_byte};
  assign want   = start_byte ^ len_hi_r ^ rx_byte;
  assign limit  = ({8'd0, max_body_len} < LEN_CAP) ? {8'd0, max_body_len} : LEN_CAP;
  assign hdr_ok = (cksum_r == want) && (len != 16'd0) && (len <= limit);
  assign fin    = (remain_r <= 8'd1);

  // next state and result
  always_comb begin
    phase_nxt    = phase_r;
    cksum_nxt    = cksum_r;
    len_hi_nxt   = len_hi_r;
    decl_len_nxt = decl_len_r;
    remain_nxt   = remain_r;
    res_valid    = 1'b0;
    res          = '{event_kind: EV_PAYLOAD, data_byte: 8'd0, last: 1'b0,
                     frame_length: 16'd0};
    case (phase_r)
      PH_START: begin
        cksum_nxt = rx_byte;
        phase_nxt = PH_CKSM;
      end
      PH_CKSM: begin
        len_hi_nxt = rx_byte;
        phase_nxt  = PH_LENH;
      end
      PH_LENH: begin
        decl_len_nxt = len;
        if (hdr_ok) begin
          // limit never exceeds an 8-bit value
          remain_nxt = len[7:0];
          phase_nxt  = PH_BODY;
        end else begin
          remain_nxt       = 8'd0;
          phase_nxt        = PH_HUNT;
          res_valid        = 1'b1;
          res.event_kind   = EV_REJECT;
          res.frame_length = len;
        end
      end
      PH_BODY: begin
        res_valid        = 1'b1;
        res.event_kind   = EV_PAYLOAD;
        res.data_byte    = rx_byte;
        res.last         = fin;
        res.frame_length = decl_len_r;
        if (fin) begin
          remain_nxt = 8'd0;
          phase_nxt  = PH_HUNT;
        end else begin
          remain_nxt = remain_r - 8'd1;
        end
      end
      default: begin
        // hunting: only the start byte opens a frame
        phase_nxt = (rx_byte == start_byte) ? PH_START : PH_HUNT;
      end
    endcase
  end

  // parser state, updated once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      cksum_r    <= 8'd0;
      len_hi_r   <= 8'd0;
      decl_len_r <= 16'd0;
      remain_r   <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cksum_r    <= cksum_nxt;
      len_hi_r   <= len_hi_nxt;
      decl_len_r <= decl_len_nxt;
      remain_r   <= remain_nxt;
    end
  end

endmodule

// ===== sv/lfxr_out_stage.sv =====
// ----------------------------------------------------------------------------
// lfxr_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module lfxr_out_stage import lfxr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  logic    res_valid,
  input  result_t res,
  output logic    load_ok,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // register may load when empty or draining this cycle
  assign load_ok   = !valid_r || !out_stall;
  assign valid_nxt = load_ok ? (step && res_valid) : valid_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load_ok && step && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== sv/length_framed_xor_header_receiver_top.sv =====
// ----------------------------------------------------------------------------
// length_framed_xor_header_receiver_top
// Recovers frames of start byte, xor checksum, 16-bit big-endian length and
// body from a byte stream; emits body bytes and header reject events.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in_     | in        | in_valid / in_stall | rx_byte
//   out_    | out       | out_valid/out_stall | event_kind, data_byte, last,
//           |           |                     | frame_length
//   cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
// One byte per cycle sustained while out_stall is low; a byte passes the input
// register, then parser logic into the result register.
// Synchronous active-low reset clears both stages and the parser to hunting
// and loads the configuration reset values.
// A stalled output holds its result; the input stalls only while both the
// input register and the result register are occupied and out_stall is high.
// ----------------------------------------------------------------------------
module length_framed_xor_header_receiver_top import lfxr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  output logic [15:0] out_frame_length,
  // configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] start_byte_r;
  logic [7:0] max_body_len_r;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       load_ok;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= START_BYTE_RST;
      max_body_len_r <= MAX_BODY_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:   start_byte_r   <= cfg_wdata;
        CFG_MAX_BODY_LEN: max_body_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser consumes the held byte whenever the result register can load
  assign step = s1_valid && load_ok;

  lfxr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .adv_ok     (load_ok),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  lfxr_frame_fsm u_frame_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (s1_byte),
    .start_byte   (start_byte_r),
    .max_body_len (max_body_len_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  lfxr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result fields
  assign out_event_kind   = out_res.event_kind;
  assign out_data_byte    = out_res.data_byte;
  assign out_last         = out_res.last;
  assign out_frame_length = out_res.frame_length;

endmodule
